/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Implication whose consequent is checked later, after the delay given by dly.
`define ASSERT_IMPL_DLY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("delayed implication check failed");

`endif

/* hw/rtl/kvb_pkg.sv */
// ----------------------------------------------------------------------------
// kvb_pkg
// Types and constants of the keyframe vertex blend pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package kvb_pkg;

   typedef logic signed [15:0] lane_type;     // one Q8.8 / Q1.14 / Q2.14 component
   typedef logic signed [16:0] diff_type;     // target minus source
   typedef logic signed [33:0] prod_type;     // difference times weight
   typedef logic        [16:0] weight_type;   // Q1.16 weight, 1.0 = 0x10000
   typedef logic        [14:0] env_v_type;

   localparam int LANE_COUNT = 7;             // pos x,y,z, normal x,y,z, env U
   localparam int XYZ_LANES  = 3;
   localparam int NRM_BASE   = 3;
   localparam int ENV_U_LANE = 6;
   localparam int NRM_Z_LANE = 5;
   localparam int PIPE_DEPTH = 4;

   localparam weight_type WEIGHT_ONE = 17'h10000;
   localparam diff_type   ENV_BIAS   = 17'sd16384;
   localparam env_v_type  ENV_V_MAX  = 15'd16384;

   // Weights above 1.0 saturate to exactly 1.0.
   function automatic weight_type clamp_weight(input weight_type w);
      weight_type r;
      r = w[16] ? WEIGHT_ONE : w;
      return r;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/kvb_blend_lane.sv */
// ----------------------------------------------------------------------------
// kvb_blend_lane
// One component of the blend: a + floor((b - a) * w / 65536) in three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module kvb_blend_lane import kvb_pkg::*; (
   input  wire logic       clock,
   input  wire lane_type   a_in,
   input  wire lane_type   b_in,
   input  wire weight_type weight,
   output lane_type        res_out
);

   lane_type   a1_ff, a1_in;
   diff_type   d1_ff, d1_in;
   weight_type w1_ff, w1_in;
   lane_type   a2_ff, a2_in;
   prod_type   prod2_ff, prod2_in;
   lane_type   res3_ff, res3_in;

   // Stage 1: difference of the two keyframes.
   always_comb begin
      a1_in = a_in;
      d1_in = {b_in[15], b_in} - {a_in[15], a_in};
      w1_in = weight;
   end

   // Stage 2: signed difference times unsigned weight.
   always_comb begin
      a2_in    = a1_ff;
      prod2_in = d1_ff * $signed({1'b0, w1_ff});
   end

   // Stage 3: the arithmetic shift by 16 floors; only the low 16 bits survive.
   always_comb begin
      res3_in = lane_type'(a2_ff + prod2_ff[31:16]);
   end

   always_ff @(posedge clock) begin
      a1_ff    <= a1_in;
      d1_ff    <= d1_in;
      w1_ff    <= w1_in;
      a2_ff    <= a2_in;
      prod2_ff <= prod2_in;
      res3_ff  <= res3_in;
   end

   assign res_out = res3_ff;

endmodule

`default_nettype wire

/* hw/rtl/kvb_env_v.sv */
// ----------------------------------------------------------------------------
// kvb_env_v
// Environment V from the blended normal z, saturated to [0, 1.0], registered.
// ----------------------------------------------------------------------------
`default_nettype none

module kvb_env_v import kvb_pkg::*; (
   input  wire logic     clock,
   input  wire lane_type nrm_z,
   output env_v_type     env_v_out
);

   diff_type  env_sum;
   env_v_type env_v_ff, env_v_in;

   always_comb begin
      env_sum = $signed({nrm_z[15], nrm_z}) + ENV_BIAS;
      if (env_sum[16]) begin
         env_v_in = '0;
      end else if (env_sum[15:1] > ENV_V_MAX) begin
         env_v_in = ENV_V_MAX;
      end else begin
         env_v_in = env_sum[15:1];
      end
   end

   always_ff @(posedge clock) begin
      env_v_ff <= env_v_in;
   end

   assign env_v_out = env_v_ff;

endmodule

`default_nettype wire

/* hw/rtl/keyframe_vertex_blend_top.sv */
// ----------------------------------------------------------------------------
// keyframe_vertex_blend_top
// Keyframe vertex morph: blends source and target vertices by a Q1.16 weight.
// ----------------------------------------------------------------------------
// Usage. A vertex word is offered on the req_ ports with start high; it is
// taken at any rising edge where start is high and busy is low. This block
// never stalls, so busy is always low and a new word can be taken on every
// clock, giving a sustained rate of one vertex per cycle.
// Each accepted word produces exactly one result word on the rsp_ ports,
// marked by rsp_valid for one cycle. The strobe and the result word pass
// through four register stages (stage 1 difference, stage 2 multiply,
// stage 3 add, stage 4 output register with environment V).
// Results leave in request order.
// The receiver cannot hold results off, so there is no back-pressure path.
// The blend weight is written through csr_wr_en / csr_wr_data; it should only
// change while no vertex is in flight. Values above 1.0 saturate to 1.0.
// A synchronous reset clears the weight to zero and empties the pipeline;
// words in flight at reset are dropped without a result.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_vertex_blend_top import kvb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        start,
   output logic             busy,
   input  wire logic [47:0] req_src_position,
   input  wire logic [47:0] req_src_normal,
   input  wire lane_type    req_src_env_u,
   input  wire logic [47:0] req_dst_position,
   input  wire logic [47:0] req_dst_normal,
   input  wire lane_type    req_dst_env_u,
   input  wire logic        req_range_end,
   // Response channel.
   output logic             rsp_valid,
   output logic [47:0]      rsp_blended_position,
   output logic [47:0]      rsp_blended_normal,
   output lane_type         rsp_blended_env_u,
   output env_v_type        rsp_env_v,
   output logic             rsp_range_done,
   // Configuration.
   input  wire logic        csr_wr_en,
   input  wire weight_type  csr_wr_data
);

   weight_type weight_ff, weight_in;
   weight_type weight_eff;

   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;
   logic [PIPE_DEPTH-1:0] range_ff, range_in;

   lane_type lane_a   [LANE_COUNT];
   lane_type lane_b   [LANE_COUNT];
   lane_type lane_res [LANE_COUNT];

   logic [47:0] pos_ff, pos_in;
   logic [47:0] nrm_ff, nrm_in;
   lane_type    env_u_ff, env_u_in;
   env_v_type   env_v;

   // The pipeline never stalls.
   assign busy = 1'b0;

   // Weight register; the clamp is applied once here for all lanes.
   always_comb begin
      weight_in = csr_wr_en ? csr_wr_data : weight_ff;
   end
   assign weight_eff = clamp_weight(weight_ff);

   // Valid bits and the range-end flag travel with the data.
   always_comb begin
      valid_in = {valid_ff[PIPE_DEPTH-2:0], start & ~busy};
      range_in = {range_ff[PIPE_DEPTH-2:0], req_range_end};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= '0;
         valid_ff  <= '0;
      end else begin
         weight_ff <= weight_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      range_ff <= range_in;
   end

   // Unpack the packed lanes: x lowest.
   genvar k;
   generate
      for (k = 0; k < XYZ_LANES; k++) begin : g_unpack
         assign lane_a[k]            = req_src_position[16*k +: 16];
         assign lane_b[k]            = req_dst_position[16*k +: 16];
         assign lane_a[NRM_BASE + k] = req_src_normal[16*k +: 16];
         assign lane_b[NRM_BASE + k] = req_dst_normal[16*k +: 16];
      end
   endgenerate
   assign lane_a[ENV_U_LANE] = req_src_env_u;
   assign lane_b[ENV_U_LANE] = req_dst_env_u;

   generate
      for (k = 0; k < LANE_COUNT; k++) begin : g_lane
         kvb_blend_lane u_lane (
            .clock   (clock),
            .a_in    (lane_a[k]),
            .b_in    (lane_b[k]),
            .weight  (weight_eff),
            .res_out (lane_res[k])
         );
      end
   endgenerate

   // Stage 4: output registers, environment V computed alongside.
   kvb_env_v u_env_v (
      .clock     (clock),
      .nrm_z     (lane_res[NRM_Z_LANE]),
      .env_v_out (env_v)
   );

   always_comb begin
      pos_in   = {lane_res[2], lane_res[1], lane_res[0]};
      nrm_in   = {lane_res[NRM_BASE + 2], lane_res[NRM_BASE + 1], lane_res[NRM_BASE]};
      env_u_in = lane_res[ENV_U_LANE];
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      nrm_ff   <= nrm_in;
      env_u_ff <= env_u_in;
   end

   assign rsp_valid            = valid_ff[PIPE_DEPTH-1];
   assign rsp_range_done       = range_ff[PIPE_DEPTH-1];
   assign rsp_blended_position = pos_ff;
   assign rsp_blended_normal   = nrm_ff;
   assign rsp_blended_env_u    = env_u_ff;
   assign rsp_env_v            = env_v;

endmodule

`default_nettype wire

/* hw/rtl/kvb_checker.sv */
// ----------------------------------------------------------------------------
// kvb_checker
// Port-level checks of the blend pipeline: timing and flag ordering.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kvb_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_range_end,
   input wire logic rsp_valid,
   input wire logic rsp_range_done
);

   // Every accepted word yields a result.
   `ASSERT_IMPL_DLY(a_accept_to_rsp, clock, reset, start && !busy, 4, rsp_valid)

   // No result appears without a word having been taken before it.
   `ASSERT_IMPL(a_rsp_has_req, clock, reset, rsp_valid, $past(start && !busy, 4))

   // The range-end flag comes out with its own word.
   `ASSERT_IMPL(a_range_order, clock, reset, rsp_valid, rsp_range_done == $past(req_range_end, 4))

endmodule

bind keyframe_vertex_blend_top kvb_checker u_kvb_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_range_end  (req_range_end),
   .rsp_valid      (rsp_valid),
   .rsp_range_done (rsp_range_done)
);

`default_nettype wire
